// ===== hdl/etd_pkg.sv =====
// shared constants, types and tables for the epoch to calendar date converter
package etd_pkg;

  // field widths
  localparam int unsigned EPOCH_W = 32;
  localparam int unsigned DAYS_W  = 16;
  localparam int unsigned SOD_W   = 17;
  localparam int unsigned YEAR_W  = 12;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DOM_W   = 5;
  localparam int unsigned HOUR_W  = 5;
  localparam int unsigned MIN_W   = 6;
  localparam int unsigned SEC_W   = 6;
  localparam int unsigned WDAY_W  = 3;

  // pipeline depths: two stages for the day split, then the date path
  localparam int unsigned DATE_LAT   = 7;
  localparam int unsigned PIPE_DEPTH = 2 + DATE_LAT;
  localparam int unsigned TOD_DELAY  = PIPE_DEPTH - 6;

  // seconds per day; t / 86400 is (t >> 7) / 675 by reciprocal, exact below 2^25
  localparam logic [31:0] SECS_PER_DAY = 32'd86400;
  localparam logic [25:0] RECIP_DAY    = 26'd50903317;
  localparam int unsigned DAY_SHIFT    = 35;

  // seconds of day to hour: (sod >> 4) / 225, exact below 2^13
  localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [13:0] RECIP_HOUR    = 14'd9321;

  // seconds of hour to minute: (mos >> 2) / 15, exact below 2^10
  localparam logic [11:0] SECS_PER_MIN = 12'd60;
  localparam logic [10:0] RECIP_MIN    = 11'd1093;

  // weekday: (days + 4) mod 7, quotient exact below 2^16
  localparam logic [15:0] WDAY_OFFSET = 16'd4;
  localparam logic [15:0] DAYS_PER_WK = 16'd7;
  localparam logic [16:0] RECIP_WEEK  = 17'd74899;

  // date path works on a four-year cycle counted from 1968-03-01;
  // 2100 is not a leap year, so days from 2100-03-01 on are moved up by one
  localparam logic [15:0] CYCLE_OFFSET  = 16'd671;
  localparam logic [15:0] SKIP_DAY      = 16'd47541;
  localparam logic [15:0] DAYS_PER_CYC  = 16'd1461;
  localparam logic [16:0] RECIP_CYCLE   = 17'd91868;
  localparam logic [10:0] DAYS_PER_YEAR = 11'd365;
  localparam logic [11:0] RECIP_YEAR    = 12'd2873;
  localparam logic [11:0] RECIP_MPOS    = 12'd3427;
  localparam logic [11:0] BASE_YEAR     = 12'd1968;
  localparam logic [3:0]  FIRST_JAN_MP  = 4'd10;

  // calendar part of one result item
  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DOM_W-1:0]   day_of_month;
  } date_t;

  // time of day part of one result item
  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
    logic [WDAY_W-1:0] weekday;
  } tod_t;

  // first day of each month in a year starting in March
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] d;
    case (mp)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd61;
      4'd3:    d = 9'd92;
      4'd4:    d = 9'd122;
      4'd5:    d = 9'd153;
      4'd6:    d = 9'd184;
      4'd7:    d = 9'd214;
      4'd8:    d = 9'd245;
      4'd9:    d = 9'd275;
      4'd10:   d = 9'd306;
      4'd11:   d = 9'd337;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== hdl/etd_date.sv =====
// date pipeline: whole days since 1970 to year, month and day of month
module etd_date (
  input  logic                       clk,
  input  logic [etd_pkg::DAYS_W-1:0] days,
  output etd_pkg::date_t             date
);

  logic [15:0]         z1_r;
  logic [32:0]         cprod2_r;
  logic [15:0]         z2_r;
  logic [5:0]          cyc3_r;
  logic [10:0]         r3_r;
  logic [22:0]         yprod4_r;
  logic [10:0]         r4_r;
  logic [5:0]          cyc4_r;
  logic [1:0]          yoc5_r;
  logic [8:0]          doy5_r;
  logic [5:0]          cyc5_r;
  logic [22:0]         mprod6_r;
  logic [8:0]          doy6_r;
  logic [1:0]          yoc6_r;
  logic [5:0]          cyc6_r;
  etd_pkg::date_t      date_r;

  logic [15:0]         z1_nxt;
  logic [5:0]          cyc3_nxt;
  logic [15:0]         r3_full;
  logic [2:0]          yq;
  logic [1:0]          yoc5_nxt;
  logic [10:0]         doy_full;
  logic [10:0]         mpos_x;
  logic [3:0]          mp;
  logic [8:0]          dom_full;
  etd_pkg::date_t      date_nxt;

  // shift onto the march-based cycle, with the missing leap day of 2100 inserted
  always_comb begin
    z1_nxt = days + etd_pkg::CYCLE_OFFSET + {15'd0, (days >= etd_pkg::SKIP_DAY)};
  end

  // cycle number and day within the four-year cycle
  always_comb begin
    cyc3_nxt = cprod2_r[32:27];
    r3_full  = z2_r - 16'({10'd0, cyc3_nxt} * etd_pkg::DAYS_PER_CYC);
  end

  // year within cycle; the last day of a cycle belongs to its fourth year
  always_comb begin
    yq       = yprod4_r[22:20];
    yoc5_nxt = (yq == 3'd4) ? 2'd3 : yq[1:0];
    doy_full = r4_r - 11'({9'd0, yoc5_nxt} * etd_pkg::DAYS_PER_YEAR);
    mpos_x   = 11'({2'd0, doy5_r} * 11'd5) + 11'd2;
  end

  // month position, day of month and year
  always_comb begin
    mp       = mprod6_r[22:19];
    dom_full = doy6_r - etd_pkg::month_start(mp) + 9'd1;
    date_nxt.day_of_month = dom_full[4:0];
    date_nxt.month = (mp < etd_pkg::FIRST_JAN_MP) ? (mp + 4'd3) : (mp - 4'd9);
    date_nxt.year  = etd_pkg::BASE_YEAR + {4'd0, cyc6_r, 2'b00} + {10'd0, yoc6_r}
                   + {11'd0, (mp >= etd_pkg::FIRST_JAN_MP)};
  end

  // pipeline registers, payload only
  always_ff @(posedge clk) begin
    z1_r     <= z1_nxt;
    cprod2_r <= 33'(z1_r) * 33'(etd_pkg::RECIP_CYCLE);
    z2_r     <= z1_r;
    cyc3_r   <= cyc3_nxt;
    r3_r     <= r3_full[10:0];
    yprod4_r <= 23'(r3_r) * 23'(etd_pkg::RECIP_YEAR);
    r4_r     <= r3_r;
    cyc4_r   <= cyc3_r;
    yoc5_r   <= yoc5_nxt;
    doy5_r   <= doy_full[8:0];
    cyc5_r   <= cyc4_r;
    mprod6_r <= 23'(mpos_x) * 23'(etd_pkg::RECIP_MPOS);
    doy6_r   <= doy5_r;
    yoc6_r   <= yoc5_r;
    cyc6_r   <= cyc5_r;
    date_r   <= date_nxt;
  end

  assign date = date_r;

endmodule

// ===== hdl/epoch_to_datetime.sv =====
// top level: unix seconds to gregorian date, time of day and weekday
//
// One item can be started in every clock cycle and busy stays low outside
// reset; the result appears on the out_ ports for one cycle with out_valid
// high. The latency is set by the chain of constant-reciprocal multiplies
// and their corrections (day split, four-year cycle, year within cycle,
// month), each given a stage of its own. The receiver cannot stall, so
// nothing is held back.
module epoch_to_datetime (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [etd_pkg::EPOCH_W-1:0] in_epoch_seconds,
  output logic                        out_valid,
  output logic [etd_pkg::YEAR_W-1:0]  out_year,
  output logic [etd_pkg::MONTH_W-1:0] out_month,
  output logic [etd_pkg::DOM_W-1:0]   out_day_of_month,
  output logic [etd_pkg::HOUR_W-1:0]  out_hour,
  output logic [etd_pkg::MIN_W-1:0]   out_minute,
  output logic [etd_pkg::SEC_W-1:0]   out_second,
  output logic [etd_pkg::WDAY_W-1:0]  out_weekday
);

  logic [etd_pkg::PIPE_DEPTH-1:0] valid_r;
  logic [etd_pkg::PIPE_DEPTH-1:0] valid_nxt;

  logic [31:0]   t1_r;
  logic [50:0]   dprod1_r;
  logic [15:0]   days2_r;
  logic [16:0]   sod2_r;
  logic [26:0]   hprod3_r;
  logic [16:0]   sod3_r;
  logic [32:0]   wprod3_r;
  logic [15:0]   wx3_r;
  logic [4:0]    hour4_r;
  logic [11:0]   mos4_r;
  logic [2:0]    wd4_r;
  logic [20:0]   mprod5_r;
  logic [11:0]   mos5_r;
  logic [4:0]    hour5_r;
  logic [2:0]    wd5_r;
  etd_pkg::tod_t tod6_r;
  etd_pkg::tod_t tod_tail_r [etd_pkg::TOD_DELAY];

  logic [15:0]    days2_nxt;
  logic [31:0]    sod_full;
  logic [15:0]    wx3_nxt;
  logic [4:0]     hour4_nxt;
  logic [16:0]    mos_full;
  logic [13:0]    wq;
  logic [15:0]    wd_full;
  logic [5:0]     min6_nxt;
  logic [11:0]    sec_full;
  etd_pkg::tod_t  tod6_nxt;
  etd_pkg::date_t date;

  // no back-pressure: items are refused only while in reset
  assign busy = ~rst_n;

  // valid bits follow the items down the pipeline
  assign valid_nxt = {valid_r[etd_pkg::PIPE_DEPTH-2:0], start & ~busy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // whole days and seconds of the day, and the offset day count for the weekday
  always_comb begin
    days2_nxt = dprod1_r[50:etd_pkg::DAY_SHIFT];
    sod_full  = t1_r - 32'(days2_nxt) * etd_pkg::SECS_PER_DAY;
    wx3_nxt   = days2_r + etd_pkg::WDAY_OFFSET;
  end

  // hour and seconds of the hour, weekday remainder
  always_comb begin
    hour4_nxt = hprod3_r[25:21];
    mos_full  = sod3_r - 17'(hour4_nxt) * etd_pkg::SECS_PER_HOUR;
    wq        = wprod3_r[32:19];
    wd_full   = wx3_r - 16'(wq) * etd_pkg::DAYS_PER_WK;
  end

  // minute and second
  always_comb begin
    min6_nxt         = mprod5_r[19:14];
    sec_full         = mos5_r - 12'(min6_nxt) * etd_pkg::SECS_PER_MIN;
    tod6_nxt.hour    = hour5_r;
    tod6_nxt.minute  = min6_nxt;
    tod6_nxt.second  = sec_full[5:0];
    tod6_nxt.weekday = wd5_r;
  end

  // time of day pipeline, payload only
  always_ff @(posedge clk) begin
    t1_r     <= in_epoch_seconds;
    dprod1_r <= 51'(in_epoch_seconds[31:7]) * 51'(etd_pkg::RECIP_DAY);
    days2_r  <= days2_nxt;
    sod2_r   <= sod_full[16:0];
    hprod3_r <= 27'(sod2_r[16:4]) * 27'(etd_pkg::RECIP_HOUR);
    sod3_r   <= sod2_r;
    wprod3_r <= 33'(wx3_nxt) * 33'(etd_pkg::RECIP_WEEK);
    wx3_r    <= wx3_nxt;
    hour4_r  <= hour4_nxt;
    mos4_r   <= mos_full[11:0];
    wd4_r    <= wd_full[2:0];
    mprod5_r <= 21'(mos4_r[11:2]) * 21'(etd_pkg::RECIP_MIN);
    mos5_r   <= mos4_r;
    hour5_r  <= hour4_r;
    wd5_r    <= wd4_r;
    tod6_r   <= tod6_nxt;
  end

  // delay line that lines the time of day up with the date path
  always_ff @(posedge clk) begin
    tod_tail_r[0] <= tod6_r;
    for (int i = 1; i < etd_pkg::TOD_DELAY; i++) begin
      tod_tail_r[i] <= tod_tail_r[i-1];
    end
  end

  // calendar date from the day count
  etd_date u_date (
    .clk  (clk),
    .days (days2_r),
    .date (date)
  );

  // result ports
  assign out_valid        = valid_r[etd_pkg::PIPE_DEPTH-1];
  assign out_year         = date.year;
  assign out_month        = date.month;
  assign out_day_of_month = date.day_of_month;
  assign out_hour         = tod_tail_r[etd_pkg::TOD_DELAY-1].hour;
  assign out_minute       = tod_tail_r[etd_pkg::TOD_DELAY-1].minute;
  assign out_second       = tod_tail_r[etd_pkg::TOD_DELAY-1].second;
  assign out_weekday      = tod_tail_r[etd_pkg::TOD_DELAY-1].weekday;

endmodule

// ===== hdl/etd_checker.sv =====
// port-level checks for the epoch to calendar date converter, bound to the top level
module etd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic [etd_pkg::EPOCH_W-1:0] in_epoch_seconds,
  input logic                        out_valid,
  input logic [etd_pkg::YEAR_W-1:0]  out_year,
  input logic [etd_pkg::MONTH_W-1:0] out_month,
  input logic [etd_pkg::DOM_W-1:0]   out_day_of_month,
  input logic [etd_pkg::HOUR_W-1:0]  out_hour,
  input logic [etd_pkg::MIN_W-1:0]   out_minute,
  input logic [etd_pkg::SEC_W-1:0]   out_second,
  input logic [etd_pkg::WDAY_W-1:0]  out_weekday
);

  // busy only ever reflects reset
  a_busy_reset: assert property (@(posedge clk) busy == !rst_n)
    else $error("busy high outside reset");

  // every item taken comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(etd_pkg::PIPE_DEPTH) out_valid)
    else $error("item taken but no result after pipeline latency");

  // no result without an item taken that many cycles earlier
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, etd_pkg::PIPE_DEPTH))
    else $error("result without a matching item");

  // calendar fields stay in range
  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_year >= 12'd1970 && out_year <= 12'd2106 &&
                   out_month >= 4'd1 && out_month <= 4'd12 &&
                   out_day_of_month >= 5'd1))
    else $error("date field out of range");

  // time of day and weekday stay in range
  a_tod_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hour <= 5'd23 && out_minute <= 6'd59 &&
                   out_second <= 6'd59 && out_weekday <= 3'd6))
    else $error("time of day field out of range");

endmodule

bind epoch_to_datetime etd_checker u_etd_checker (.*);

// ===== test/tb_top.sv =====
// testbench for the epoch to calendar date converter: directed and random timestamps
`timescale 1ns / 1ps

module tb_top;

  // one calendar result item at the block's widths
  typedef struct packed {
    logic [etd_pkg::YEAR_W-1:0]  year;
    logic [etd_pkg::MONTH_W-1:0] month;
    logic [etd_pkg::DOM_W-1:0]   day_of_month;
    logic [etd_pkg::HOUR_W-1:0]  hour;
    logic [etd_pkg::MIN_W-1:0]   minute;
    logic [etd_pkg::SEC_W-1:0]   second;
    logic [etd_pkg::WDAY_W-1:0]  weekday;
  } datetime_t;

  // holds the dates predicted from accepted timestamps, oldest first
  class calendar_scoreboard;
    datetime_t   pending_dates[$];
    int unsigned mismatches;
    int unsigned dates_checked;
    int unsigned stamps_taken;

    function new();
      mismatches    = 0;
      dates_checked = 0;
      stamps_taken  = 0;
    endfunction

    function bit is_leap(int unsigned yr);
      return ((yr % 4) == 0 && (yr % 100) != 0) || ((yr % 400) == 0);
    endfunction

    // gregorian date, time of day and weekday of a unix timestamp
    function datetime_t predict_datetime(logic [etd_pkg::EPOCH_W-1:0] secs);
      datetime_t   r;
      int unsigned t;
      int unsigned total_days;
      int unsigned days;
      int unsigned sod;
      int unsigned yr;
      int unsigned mon;
      int unsigned ylen;
      int unsigned mlen;
      t          = secs;
      total_days = t / 86400;
      sod        = t % 86400;
      days       = total_days;
      // strip whole years from 1970
      yr = 1970;
      ylen = is_leap(yr) ? 366 : 365;
      while (days >= ylen) begin
        days -= ylen;
        yr++;
        ylen = is_leap(yr) ? 366 : 365;
      end
      // strip whole months, february long in leap years
      mon = 1;
      while (mon < 12) begin
        case (mon)
          2:       mlen = is_leap(yr) ? 29 : 28;
          4, 6, 9: mlen = 30;
          11:      mlen = 30;
          default: mlen = 31;
        endcase
        if (days < mlen) break;
        days -= mlen;
        mon++;
      end
      r.year         = yr[etd_pkg::YEAR_W-1:0];
      r.month        = mon[etd_pkg::MONTH_W-1:0];
      r.day_of_month = etd_pkg::DOM_W'(days + 1);
      r.hour         = etd_pkg::HOUR_W'(sod / 3600);
      r.minute       = etd_pkg::MIN_W'((sod % 3600) / 60);
      r.second       = etd_pkg::SEC_W'(sod % 60);
      r.weekday      = etd_pkg::WDAY_W'((total_days + 4) % 7);
      return r;
    endfunction

    task report(string what, int unsigned got, int unsigned want);
      $display("mismatch at result %0d: %s got %0d want %0d", dates_checked, what, got, want);
      mismatches++;
    endtask

    function void note_epoch(logic [etd_pkg::EPOCH_W-1:0] secs);
      pending_dates.push_back(predict_datetime(secs));
      stamps_taken++;
    endfunction

    task check_result(datetime_t got);
      datetime_t want;
      if (pending_dates.size() == 0) begin
        report("result item with no timestamp waiting", 0, 0);
        return;
      end
      want = pending_dates.pop_front();
      if (got.year != want.year) report("year", 32'(got.year), 32'(want.year));
      if (got.month != want.month) report("month", 32'(got.month), 32'(want.month));
      if (got.day_of_month != want.day_of_month)
        report("day_of_month", 32'(got.day_of_month), 32'(want.day_of_month));
      if (got.hour != want.hour) report("hour", 32'(got.hour), 32'(want.hour));
      if (got.minute != want.minute) report("minute", 32'(got.minute), 32'(want.minute));
      if (got.second != want.second) report("second", 32'(got.second), 32'(want.second));
      if (got.weekday != want.weekday)
        report("weekday", 32'(got.weekday), 32'(want.weekday));
      dates_checked++;
    endtask
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  logic [etd_pkg::EPOCH_W-1:0]   in_epoch_seconds;
  logic                          out_valid;
  logic [etd_pkg::YEAR_W-1:0]    out_year;
  logic [etd_pkg::MONTH_W-1:0]   out_month;
  logic [etd_pkg::DOM_W-1:0]     out_day_of_month;
  logic [etd_pkg::HOUR_W-1:0]    out_hour;
  logic [etd_pkg::MIN_W-1:0]     out_minute;
  logic [etd_pkg::SEC_W-1:0]     out_second;
  logic [etd_pkg::WDAY_W-1:0]    out_weekday;
  datetime_t                     seen_date;

  calendar_scoreboard sb = new();

  epoch_to_datetime uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_epoch_seconds (in_epoch_seconds),
    .out_valid        (out_valid),
    .out_year         (out_year),
    .out_month        (out_month),
    .out_day_of_month (out_day_of_month),
    .out_hour         (out_hour),
    .out_minute       (out_minute),
    .out_second       (out_second),
    .out_weekday      (out_weekday)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  assign seen_date = {out_year, out_month, out_day_of_month, out_hour,
                      out_minute, out_second, out_weekday};

  // note accepted timestamps and check result items at the same edge
  always @(posedge clk) begin
    if (rst_n && start && !busy) sb.note_epoch(in_epoch_seconds);
    if (rst_n && out_valid) sb.check_result(seen_date);
  end

  // present one timestamp and hold it until taken
  task automatic send_epoch(input logic [etd_pkg::EPOCH_W-1:0] secs);
    start            <= 1'b1;
    in_epoch_seconds <= secs;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // sender gap with noise on the data port
  task automatic idle_cycles(input int unsigned n);
    repeat (n) begin
      start            <= 1'b0;
      in_epoch_seconds <= $urandom;
      @(posedge clk);
    end
  endtask

  // random timestamp, weighted towards day edges, the end of february 2100 and range edges
  function automatic logic [etd_pkg::EPOCH_W-1:0] random_epoch();
    longint unsigned v;
    int unsigned     pick;
    int unsigned     day;
    pick = $urandom_range(99);
    day  = $urandom_range(49710);
    if (pick < 40) begin
      v = 64'($urandom);
    end else if (pick < 70) begin
      // first or last second of a random day, or a random second of it
      case ($urandom_range(2))
        0:       v = longint'(day) * 86400;
        1:       v = longint'(day) * 86400 + 86399;
        default: v = longint'(day) * 86400 + $urandom_range(86399);
      endcase
    end else if (pick < 80) begin
      // around the end of february 2100, a century that is not leap
      v = 64'd4107542400 - 64'd172800 + $urandom_range(345600);
    end else if (pick < 88) begin
      v = 64'hffff_ffff - $urandom_range(200000);
    end else begin
      v = 64'($urandom_range(32'h01ff_ffff));
    end
    if (v > 64'hffff_ffff) v = 64'hffff_ffff;
    return v[etd_pkg::EPOCH_W-1:0];
  endfunction

  // stimulus
  initial begin
    logic [etd_pkg::EPOCH_W-1:0] boundary_secs[$];
    int unsigned                 n_random;
    boundary_secs = '{32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399,
                      32'd86400, 32'd31535999, 32'd68169600, 32'd94694399,
                      32'd946684799, 32'd951782400, 32'd951868800, 32'd978307199,
                      32'h7fff_ffff, 32'h8000_0000, 32'haaaa_aaaa, 32'h5555_5555,
                      32'd4107542399, 32'd4107542400, 32'd4133980799,
                      32'hffff_fffe, 32'hffff_ffff};
    n_random         = 1400;
    start            = 1'b0;
    in_epoch_seconds = '0;
    rst_n            = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed edges, back to back with the odd gap
    foreach (boundary_secs[i]) begin
      if ($urandom_range(99) < 19) idle_cycles($urandom_range(1, 4));
      send_epoch(boundary_secs[i]);
    end

    // hold off until the pipeline has drained
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_dates.size() != 0) @(posedge clk);

    // random part; items 500 to 799 run with no gaps at all
    for (int unsigned k = 0; k < n_random; k++) begin
      if ((k < 500 || k >= 800) && $urandom_range(99) < 19)
        idle_cycles($urandom_range(1, 12));
      send_epoch(random_epoch());
    end

    // drain and let the pipeline settle
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_dates.size() != 0) @(posedge clk);
    repeat (etd_pkg::PIPE_DEPTH + 4) @(posedge clk);

    if (sb.pending_dates.size() != 0)
      sb.report("result items never seen", 32'(sb.pending_dates.size()), 0);
    $display("checked %0d result items from %0d timestamps", sb.dates_checked,
             sb.stamps_taken);
    $display("covered time of day and month edges, leap days, 2100 and the top of range");
    if (sb.mismatches == 0) begin
      $display("epoch_to_datetime verification clean");
    end else begin
      $display("epoch_to_datetime verification failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("epoch_to_datetime verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/etd_pkg.sv
hdl/etd_date.sv
hdl/epoch_to_datetime.sv
hdl/etd_checker.sv
test/tb_top.sv
